>>> design/rre_pkg.sv
`default_nettype none

package rre_pkg;

	localparam int ADDR_W = 64;
	localparam int TYPE_W = 32;
	localparam int MAP_W  = 63;
	localparam int WIN_W  = 8;

	localparam logic [TYPE_W-1:0] RELATIVE_TYPE_RESET = 32'd8;

	typedef enum logic [1:0] {
		OP_RELA = 2'd0,
		OP_REL  = 2'd1,
		OP_RELR = 2'd2
	} op_t;

	typedef enum logic {
		REG_LOAD_BIAS     = 1'b0,
		REG_RELATIVE_TYPE = 1'b1
	} reg_idx_t;

	typedef enum logic {
		MODE_STORE = 1'b0,
		MODE_ADD   = 1'b1
	} wmode_t;

	typedef enum logic {
		DK_SINGLE = 1'b0,
		DK_MAP    = 1'b1
	} dkind_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_MAP  = 1'b1
	} bk_state_t;

	// one queued job: a single command, or a bitmap to expand
	typedef struct packed {
		dkind_t            kind;
		wmode_t            mode;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] value;
		logic [MAP_W-1:0]  map;
	} desc_t;

	function automatic logic [2:0] lowest8(input logic [WIN_W-1:0] v);
		logic [2:0] idx;
		idx = 3'd0;
		for (int i = WIN_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

>>> design/rre_fifo.sv
`default_nettype none

module rre_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

`default_nettype wire

>>> design/rre_front.sv
`default_nettype none

module rre_front #(
	parameter int WORD_BITS = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  opcode,
	input  wire logic [63:0]                 entry_offset,
	input  wire logic [63:0]                 reloc_info,
	input  wire logic signed [63:0]          entry_addend,
	input  wire logic [63:0]                 packed_word,
	input  wire logic [63:0]                 load_bias,
	input  wire logic [rre_pkg::TYPE_W-1:0]  relative_type,
	input  wire logic                        q_full,
	output logic                             push,
	output rre_pkg::desc_t                   desc
);

	localparam logic [63:0] MASK       = {64{1'b1}} >> (64 - WORD_BITS);
	localparam logic [63:0] WORD_BYTES = 64'(WORD_BITS / 8);
	localparam logic [63:0] MAP_STEP   = 64'((WORD_BITS - 1) * (WORD_BITS / 8));
	localparam logic [63:0] PEND_RESET = (64'd0 - WORD_BYTES) & MASK;

	// pend_q holds the running address minus one word
	logic [63:0] pend_q;
	logic [63:0] pend_d;
	logic [63:0] bias;
	logic [63:0] word;
	logic        type_hit;
	logic        has_cmd;
	logic        accept;

	assign bias     = load_bias & MASK;
	assign word     = packed_word & MASK;
	assign type_hit = (WORD_BITS == 64) ? (reloc_info[31:0] == relative_type)
		: ({24'd0, reloc_info[7:0]} == relative_type);
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && has_cmd;

	always_comb begin
		has_cmd    = 1'b0;
		pend_d     = pend_q;
		desc.kind  = rre_pkg::DK_SINGLE;
		desc.mode  = rre_pkg::MODE_ADD;
		desc.addr  = (bias + entry_offset) & MASK;
		desc.value = bias;
		desc.map   = '0;
		unique case (rre_pkg::op_t'(opcode))
			rre_pkg::OP_RELA: begin
				has_cmd    = type_hit;
				desc.mode  = rre_pkg::MODE_STORE;
				desc.value = (bias + $unsigned(entry_addend)) & MASK;
			end
			rre_pkg::OP_REL: begin
				has_cmd = type_hit;
			end
			rre_pkg::OP_RELR: begin
				if (!word[0]) begin
					has_cmd   = 1'b1;
					desc.addr = (bias + word) & MASK;
					pend_d    = (bias + word) & MASK;
				end else begin
					has_cmd   = |word[63:1];
					desc.kind = rre_pkg::DK_MAP;
					desc.addr = pend_q;
					desc.map  = word[63:1];
					pend_d    = (pend_q + MAP_STEP) & MASK;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_RESET;
		end else if (accept) begin
			pend_q <= pend_d;
		end
	end

endmodule

`default_nettype wire

>>> design/rre_back.sv
`default_nettype none

module rre_back #(
	parameter int WORD_BITS = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire rre_pkg::desc_t q_dout,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [63:0]         target_address,
	output logic [63:0]         patch_value,
	output logic                write_mode,
	output logic                last
);

	localparam logic [63:0] MASK       = {64{1'b1}} >> (64 - WORD_BITS);
	localparam logic [63:0] WORD_BYTES = 64'(WORD_BITS / 8);
	localparam logic [63:0] WIN_STEP   = 64'(rre_pkg::WIN_W * (WORD_BITS / 8));
	localparam int          WB_SH      = $clog2(WORD_BITS / 8);

	rre_pkg::bk_state_t st_q;
	rre_pkg::bk_state_t st_d;

	logic [rre_pkg::MAP_W-1:0] map_q;
	logic [rre_pkg::MAP_W-1:0] rest;
	logic [63:0]               base_q;
	logic [63:0]               val_q;
	logic                      out_valid_q;

	logic [rre_pkg::WIN_W-1:0] win;
	logic [rre_pkg::WIN_W-1:0] sel;
	logic [2:0]                k;
	logic                      map_more;
	logic                      ld;

	logic                      emit;
	logic [63:0]               emit_addr;
	logic [63:0]               emit_val;
	rre_pkg::wmode_t           emit_mode;
	logic                      emit_last;

	assign ld        = !out_valid_q || out_ready;
	assign win       = map_q[rre_pkg::WIN_W-1:0];
	assign k         = rre_pkg::lowest8(win);
	assign sel       = rre_pkg::WIN_W'(1) << k;
	assign rest      = map_q & ~{{(rre_pkg::MAP_W - rre_pkg::WIN_W){1'b0}}, sel};
	assign map_more  = |rest;
	assign out_valid = out_valid_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			rre_pkg::BK_IDLE: begin
				if (!q_empty && q_dout.kind == rre_pkg::DK_MAP) begin
					st_d = rre_pkg::BK_MAP;
				end
			end
			rre_pkg::BK_MAP: begin
				if (win != '0 && ld && !map_more) begin
					st_d = rre_pkg::BK_IDLE;
				end
			end
			default: st_d = rre_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_addr = q_dout.addr;
		emit_val  = q_dout.value;
		emit_mode = q_dout.mode;
		emit_last = 1'b1;
		unique case (st_q)
			rre_pkg::BK_IDLE: begin
				if (!q_empty) begin
					if (q_dout.kind == rre_pkg::DK_MAP) begin
						q_pop = 1'b1;
					end else if (ld) begin
						q_pop = 1'b1;
						emit  = 1'b1;
					end
				end
			end
			rre_pkg::BK_MAP: begin
				emit_addr = (base_q + (64'(k) << WB_SH)) & MASK;
				emit_val  = val_q;
				emit_mode = rre_pkg::MODE_ADD;
				emit_last = !map_more;
				emit      = (win != '0) && ld;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= rre_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (ld) begin
				out_valid_q <= emit;
			end
		end
	end

	// bitmap walk: one set bit per command, empty 8-bit groups skipped
	always_ff @(posedge clk) begin
		if (st_q == rre_pkg::BK_IDLE) begin
			if (q_pop && q_dout.kind == rre_pkg::DK_MAP) begin
				map_q  <= q_dout.map;
				base_q <= (q_dout.addr + WORD_BYTES) & MASK;
				val_q  <= q_dout.value;
			end
		end else if (win == '0) begin
			map_q  <= map_q >> rre_pkg::WIN_W;
			base_q <= (base_q + WIN_STEP) & MASK;
		end else if (ld) begin
			map_q <= rest;
		end
		if (emit) begin
			target_address <= emit_addr;
			patch_value    <= emit_val;
			write_mode     <= logic'(emit_mode);
			last           <= emit_last;
		end
	end

endmodule

`default_nettype wire

>>> design/relative_relocation_engine.sv
`default_nettype none

// Relocation records in, memory patch commands out.
// Input channel: in_valid/in_ready with opcode, entry_offset, reloc_info,
// entry_addend and packed_word. Output channel: out_valid/out_ready with
// target_address, patch_value, write_mode (0 store, 1 add) and last, which
// marks the final command of an item. Items that give no command produce
// nothing on the output.
// Configuration: cfg_we writes cfg_data into the register cfg_index selects
// (0 load_bias, 1 relative_type); write only while the block is idle.
// Path: an item is decoded into a queued job; a single command then moves
// to the output register, a bitmap word via the walker. Throughput, while
// the receiver does not stall: one item per cycle for single commands; for
// a bitmap, one command per cycle per set bit, empty 8-bit groups skipped.
// The job queue between the decoder and the command walker holds
// QUEUE_DEPTH items; in_ready drops while it is full.
// Reset clears the queue, the output valid flag and the running address and
// sets load_bias to 0 and relative_type to 8. A stalled receiver holds the
// current command; the decoder keeps taking items until the queue fills.
module relative_relocation_engine #(
	parameter int WORD_BITS   = 64,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [63:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         opcode,
	input  wire logic [63:0]        entry_offset,
	input  wire logic [63:0]        reloc_info,
	input  wire logic signed [63:0] entry_addend,
	input  wire logic [63:0]        packed_word,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [63:0]             target_address,
	output logic [63:0]             patch_value,
	output logic                    write_mode,
	output logic                    last
);

	localparam int DESC_W = $bits(rre_pkg::desc_t);

	logic [63:0]                 bias_q;
	logic [rre_pkg::TYPE_W-1:0]  rtype_q;

	logic                        q_push;
	logic                        q_full;
	logic                        q_pop;
	logic                        q_empty;
	rre_pkg::desc_t              front_desc;
	logic [DESC_W-1:0]           q_din;
	logic [DESC_W-1:0]           q_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q  <= '0;
			rtype_q <= rre_pkg::RELATIVE_TYPE_RESET;
		end else if (cfg_we) begin
			unique case (rre_pkg::reg_idx_t'(cfg_index))
				rre_pkg::REG_LOAD_BIAS:     bias_q  <= cfg_data;
				rre_pkg::REG_RELATIVE_TYPE: rtype_q <= cfg_data[rre_pkg::TYPE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign q_din = front_desc;

	rre_front #(
		.WORD_BITS(WORD_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.entry_offset (entry_offset),
		.reloc_info   (reloc_info),
		.entry_addend (entry_addend),
		.packed_word  (packed_word),
		.load_bias    (bias_q),
		.relative_type(rtype_q),
		.q_full       (q_full),
		.push         (q_push),
		.desc         (front_desc)
	);

	rre_fifo #(
		.WIDTH(DESC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	rre_back #(
		.WORD_BITS(WORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_dout        (rre_pkg::desc_t'(q_dout)),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.target_address(target_address),
		.patch_value   (patch_value),
		.write_mode    (write_mode),
		.last          (last)
	);

endmodule

`default_nettype wire

>>> design/rre_checker.sv
`default_nettype none

module rre_checker #(
	parameter int WORD_BITS = 64
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [63:0]        target_address,
	input wire logic [63:0]        patch_value,
	input wire logic               write_mode,
	input wire logic               last
);

	localparam logic [63:0] MASK = {64{1'b1}} >> (64 - WORD_BITS);

	// stalled command holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(target_address)
			&& $stable(patch_value) && $stable(write_mode) && $stable(last))
		else $error("stalled command changed");

	// a store is always the only command of its item
	a_store_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_mode == logic'(rre_pkg::MODE_STORE) |-> last)
		else $error("store command without last");

	a_addr_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (target_address & ~MASK) == 64'd0 && (patch_value & ~MASK) == 64'd0)
		else $error("command bits above word width");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid out of reset");

endmodule

bind relative_relocation_engine rre_checker #(.WORD_BITS(WORD_BITS)) u_rre_checker (.*);

`default_nettype wire

>>> dv/tb_relative_relocation_engine.sv
`timescale 1ns / 100ps

module tb_relative_relocation_engine;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WORD_BYTES = 8;
	localparam int MAX_GAP = 16;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct {
		logic [63:0]     addr;
		logic [63:0]     value;
		rre_pkg::wmode_t mode;
		logic            last;
	} patch_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = rre_pkg::REG_LOAD_BIAS;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode = rre_pkg::OP_RELA;
	logic [63:0] entry_offset = '0;
	logic [63:0] reloc_info = '0;
	logic signed [63:0] entry_addend = '0;
	logic [63:0] packed_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] target_address;
	logic [63:0] patch_value;
	logic        write_mode;
	logic        last;

	// mirror of the block's registers and relr state
	logic [63:0] bias = '0;
	logic [31:0] rel_type = rre_pkg::RELATIVE_TYPE_RESET;
	logic [63:0] run_addr = '0;

	patch_cmd_t patch_q[$];

	int errors = 0;
	int items_sent = 0;
	int bitmaps_sent = 0;
	int cmds_checked = 0;
	int settings_used = 1;
	int hold_cycles = 0;
	bit no_gaps = 1'b0;
	bit no_stalls = 1'b0;

	always #1 clk = ~clk;

	relative_relocation_engine u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.entry_offset(entry_offset),
		.reloc_info(reloc_info),
		.entry_addend(entry_addend),
		.packed_word(packed_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.target_address(target_address),
		.patch_value(patch_value),
		.write_mode(write_mode),
		.last(last)
	);

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic void predict_patches(logic [1:0] op, logic [63:0] off, logic [63:0] info,
			logic [63:0] addend, logic [63:0] word);
		patch_cmd_t cmd;
		int n;
		n = 0;
		cmd.last = 1'b0;
		case (op)
		rre_pkg::OP_RELA, rre_pkg::OP_REL: begin
			if (info[31:0] == rel_type) begin
				cmd.addr = bias + off;
				cmd.value = (op == rre_pkg::OP_RELA) ? bias + addend : bias;
				cmd.mode = (op == rre_pkg::OP_RELA) ? rre_pkg::MODE_STORE : rre_pkg::MODE_ADD;
				patch_q.push_back(cmd);
				n++;
			end
		end
		rre_pkg::OP_RELR: begin
			cmd.value = bias;
			cmd.mode = rre_pkg::MODE_ADD;
			if (!word[0]) begin
				cmd.addr = bias + word;
				patch_q.push_back(cmd);
				n++;
				run_addr = cmd.addr + 64'(WORD_BYTES);
			end else begin
				for (int j = 1; j <= rre_pkg::MAP_W; j++) begin
					if (word[j]) begin
						cmd.addr = run_addr + 64'((j - 1) * WORD_BYTES);
						patch_q.push_back(cmd);
						n++;
					end
				end
				run_addr = run_addr + 64'(rre_pkg::MAP_W * WORD_BYTES);
			end
		end
		default: begin
		end
		endcase
		if (n > 0)
			patch_q[patch_q.size() - 1].last = 1'b1;
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [63:0] off, input logic [63:0] info,
			input logic [63:0] addend, input logic [63:0] word);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		entry_offset <= off;
		reloc_info <= info;
		entry_addend <= addend;
		packed_word <= word;
		do @(posedge clk); while (!in_ready);
		predict_patches(op, off, info, addend, word);
		items_sent++;
		if (op == rre_pkg::OP_RELR && word[0])
			bitmaps_sent++;
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_relr_word(bit odd);
		logic [63:0] w;
		int pick;
		pick = $urandom_range(0, 99);
		if (!odd)
			return rand64() & ~64'd1;
		if (pick < 35) begin
			w = rand64();
		end else if (pick < 85) begin
			w = '0;
			repeat ($urandom_range(1, 4)) w[$urandom_range(1, 63)] = 1'b1;
		end else if (pick < 95) begin
			w = '0;
		end else begin
			w = '1;
		end
		return w | 64'd1;
	endfunction

	task automatic send_random_item();
		int pick;
		logic [63:0] info;
		pick = $urandom_range(0, 99);
		info = rand64();
		if ($urandom_range(0, 3) != 0)
			info[31:0] = rel_type;
		if (pick < 30)
			send_item(rre_pkg::OP_RELA, rand64(), info, rand64(), rand64());
		else if (pick < 55)
			send_item(rre_pkg::OP_REL, rand64(), info, rand64(), rand64());
		else if (pick < 93)
			send_item(rre_pkg::OP_RELR, rand64(), rand64(), rand64(),
				rand_relr_word($urandom_range(0, 1)));
		else
			send_item(OP_UNUSED, rand64(), info, rand64(), rand64());
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (patch_q.size() != 0) @(negedge clk);
	endtask

	// items that give no command may still be in flight when the queue empties
	task automatic wait_idle();
		pause_until_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input rre_pkg::reg_idx_t idx, input logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == rre_pkg::REG_LOAD_BIAS)
			bias = data;
		else
			rel_type = data[31:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic report_field(input string name, input logic [63:0] exp_val,
			input logic [63:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s expected %h, got %h", $time, name, exp_val, act_val);
			errors++;
		end
	endtask

	task automatic test_directed();
		logic [63:0] t;
		t = 64'(rel_type);
		send_item(rre_pkg::OP_RELA, 64'd0, t, 64'd0, 64'd0);
		send_item(rre_pkg::OP_RELA, '1, {32'hFFFF_FFFF, rel_type}, 64'h7FFF_FFFF_FFFF_FFFF, '0);
		send_item(rre_pkg::OP_RELA, 64'h1234_5678_9ABC_DEF0, t, 64'h8000_0000_0000_0000, '1);
		send_item(rre_pkg::OP_REL, rand64(), t, rand64(), rand64());
		send_item(rre_pkg::OP_RELA, rand64(), t + 64'd1, rand64(), rand64());
		send_item(rre_pkg::OP_REL, rand64(), {rel_type, 32'd0}, rand64(), rand64());
		send_item(OP_UNUSED, '1, t, '1, '1);
		// bitmap before any offset word runs from zero
		send_item(rre_pkg::OP_RELR, '0, '0, '0, 64'h5);
		send_item(rre_pkg::OP_RELR, '0, '0, '0, 64'h1);
		send_item(rre_pkg::OP_RELR, '0, '0, '0, 64'h1000);
		send_item(rre_pkg::OP_RELR, '0, '0, '0, '1);
		send_item(rre_pkg::OP_RELR, '0, '0, '0, 64'h8000_0000_0000_0001);
		send_item(rre_pkg::OP_RELR, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE);
		send_item(rre_pkg::OP_RELR, '0, '0, '0, 64'h3);
		wait_idle();
		cfg_write(rre_pkg::REG_LOAD_BIAS, '1);
		settings_used++;
		send_item(rre_pkg::OP_RELA, 64'd1, t, 64'd2, '0);
		send_item(rre_pkg::OP_REL, 64'd5, t, '0, '0);
		send_item(rre_pkg::OP_RELR, '0, '0, '0, 64'd2);
		send_item(rre_pkg::OP_RELR, '0, '0, '0, 64'hAAAA_AAAA_AAAA_AAAB);
		send_item(OP_UNUSED, '0, '0, '0, 64'h1);
	endtask

	task automatic test_config_sweep();
		logic [63:0] b;
		logic [31:0] t;
		for (int i = 0; i < 6; i++) begin
			case (i)
			0: begin
				b = '1;
				t = rre_pkg::RELATIVE_TYPE_RESET;
			end
			1: begin
				b = 64'h8000_0000_0000_0000;
				t = 32'd0;
			end
			2: begin
				b = rand64();
				t = '1;
			end
			3: begin
				b = '0;
				t = 32'd1027;
			end
			4: begin
				b = rand64();
				t = 32'd23;
			end
			default: begin
				b = rand64();
				t = 32'd3;
			end
			endcase
			wait_idle();
			cfg_write(rre_pkg::REG_LOAD_BIAS, b);
			cfg_write(rre_pkg::REG_RELATIVE_TYPE, {$urandom(), t});
			settings_used++;
			repeat (32) send_random_item();
		end
	endtask

	task automatic test_relr_chains();
		send_item(rre_pkg::OP_RELR, rand64(), rand64(), rand64(), rand_relr_word(1'b1));
		for (int i = 0; i < 20; i++) begin
			send_item(rre_pkg::OP_RELR, rand64(), rand64(), rand64(), rand_relr_word(1'b0));
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 4) == 0)
					send_random_item();
				send_item(rre_pkg::OP_RELR, rand64(), rand64(), rand64(), rand_relr_word(1'b1));
			end
		end
	endtask

	task automatic test_backpressure();
		hold_cycles = HOLD_OFF_CYCLES;
		no_gaps = 1'b1;
		repeat (30) send_random_item();
		no_gaps = 1'b0;
	endtask

	task automatic test_drain_pause();
		repeat (3) begin
			repeat (8) send_random_item();
			pause_until_drained();
		end
	endtask

	task automatic test_back_to_back();
		no_gaps = 1'b1;
		no_stalls = 1'b1;
		repeat (40) send_random_item();
		no_gaps = 1'b0;
		no_stalls = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_config_sweep();
		test_relr_chains();
		test_backpressure();
		test_drain_pause();
		test_back_to_back();
		wait_idle();
		$display("Sent %0d items (%0d bitmap words) under %0d register settings.",
			items_sent, bitmaps_sent, settings_used);
		$display("Checked %0d patch commands, with receiver hold-off and drain pauses.",
			cmds_checked);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : receiver
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			stall = no_stalls ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid && hold_cycles == 0);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin : check_patch
		patch_cmd_t exp_cmd;
		if (arst_n && out_valid && out_ready) begin
			if (patch_q.size() == 0) begin
				$display("%0t: unexpected item, expected none, got address %h value %h",
					$time, target_address, patch_value);
				errors++;
			end else begin
				exp_cmd = patch_q.pop_front();
				cmds_checked++;
				report_field("target_address", exp_cmd.addr, target_address);
				report_field("patch_value", exp_cmd.value, patch_value);
				report_field("write_mode", 64'(exp_cmd.mode), 64'(write_mode));
				report_field("last", 64'(exp_cmd.last), 64'(last));
			end
		end
	end

	initial begin
		#3000000;
		$display("Timeout with %0d patch commands outstanding", patch_q.size());
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> relative_relocation_engine.f
design/rre_pkg.sv
design/rre_fifo.sv
design/rre_front.sv
design/rre_back.sv
design/relative_relocation_engine.sv
design/rre_checker.sv
dv/tb_relative_relocation_engine.sv
